// ===== hw/rtl/fpalu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpalu_pkg
// Shared constants and types for the signed fixed-point ALU.
// ----------------------------------------------------------------------------
package fpalu_pkg;

	// Default format: Q24.8 in a 32-bit word.
	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_BITS_DEF = 32;

	// Fixed port widths.
	localparam int DATA_BITS = 32;
	localparam int MODE_BITS = 4;

	// Operation codes.
	localparam logic [MODE_BITS-1:0] MODE_ADD  = 4'd0;
	localparam logic [MODE_BITS-1:0] MODE_SUB  = 4'd1;
	localparam logic [MODE_BITS-1:0] MODE_MUL  = 4'd2;
	localparam logic [MODE_BITS-1:0] MODE_DIV  = 4'd3;
	localparam logic [MODE_BITS-1:0] MODE_MIN  = 4'd4;
	localparam logic [MODE_BITS-1:0] MODE_MAX  = 4'd5;
	localparam logic [MODE_BITS-1:0] MODE_INC  = 4'd6;
	localparam logic [MODE_BITS-1:0] MODE_DEC  = 4'd7;
	localparam logic [MODE_BITS-1:0] MODE_FINT = 4'd8;
	localparam logic [MODE_BITS-1:0] MODE_TINT = 4'd9;

	// Per-word control and status that rides along the cell chain.
	typedef struct packed {
		logic a_greater;
		logic a_less;
		logic a_equal;
		logic div_zero;
		logic is_div;
		logic q_neg;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/fixed_point_alu_q24_8.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed fixed-point ALU: add, sub, mul, div, min, max, inc, dec and
// integer conversions, with signed compare flags on every word.
// ----------------------------------------------------------------------------
// Every mode, in Q24.8 as in any other format, passes the input stage, the
// chain of division cells and the output register. Throughput is one word per cycle while the
// output is not stalled; the chain of division cells settles one quotient bit per cell.
// The whole chain advances together; it holds only while the output word
// is stalled. Reset clears all valid bits at once.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 #(
	parameter int FRAC_BITS = fpalu_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = fpalu_pkg::WORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [fpalu_pkg::MODE_BITS-1:0]       mode,
	input  logic signed [fpalu_pkg::DATA_BITS-1:0] operand_a,
	input  logic signed [fpalu_pkg::DATA_BITS-1:0] operand_b,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [fpalu_pkg::DATA_BITS-1:0] result,
	output logic                                  a_greater,
	output logic                                  a_less,
	output logic                                  a_equal,
	output logic                                  divide_by_zero
);
	import fpalu_pkg::*;

	localparam int QUOT_BITS = WORD_BITS + FRAC_BITS;

	logic advance;

	// Input stage.
	logic signed [WORD_BITS-1:0]   a_in, b_in;
	logic                          valid_s1;
	logic [MODE_BITS-1:0]          mode_s1;
	logic signed [WORD_BITS-1:0]   a_s1, b_s1;
	logic signed [2*WORD_BITS-1:0] prod_s1;
	logic [WORD_BITS-1:0]          mag_a_s1, mag_b_s1;
	cell_ctl_t                     ctl_s1;

	// Non-division result formed from the input stage.
	logic signed [2*WORD_BITS-1:0] prod_sh;
	logic signed [WORD_BITS-1:0]   res_c0;

	// Cell chain taps.
	logic                 valid_c [0:QUOT_BITS];
	cell_ctl_t            ctl_c   [0:QUOT_BITS];
	logic [WORD_BITS-1:0] res_c   [0:QUOT_BITS];
	logic [WORD_BITS-1:0] dvs_c   [0:QUOT_BITS];
	logic [WORD_BITS-1:0] rem_c   [0:QUOT_BITS];
	logic [QUOT_BITS-1:0] sh_c    [0:QUOT_BITS];

	// Output stage.
	logic [QUOT_BITS-1:0]        quot_s;
	logic signed [WORD_BITS-1:0] res_fin;
	logic signed [WORD_BITS-1:0] res_q;
	cell_ctl_t                   ctl_q;
	logic                        valid_q;

	// The chain moves unless a finished word is held at the output.
	assign advance  = ~(valid_q & out_stall);
	assign in_stall = ~advance;

	assign a_in = operand_a[WORD_BITS-1:0];
	assign b_in = operand_b[WORD_BITS-1:0];

	// Input stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage: register operands, product, magnitudes and flags.
	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s1          <= mode;
			a_s1             <= a_in;
			b_s1             <= b_in;
			prod_s1          <= (2*WORD_BITS)'(a_in) * (2*WORD_BITS)'(b_in);
			mag_a_s1         <= a_in[WORD_BITS-1] ? WORD_BITS'(-a_in) : a_in;
			mag_b_s1         <= b_in[WORD_BITS-1] ? WORD_BITS'(-b_in) : b_in;
			ctl_s1.a_greater <= a_in > b_in;
			ctl_s1.a_less    <= a_in < b_in;
			ctl_s1.a_equal   <= a_in == b_in;
			ctl_s1.div_zero  <= (mode == MODE_DIV) && (b_in == '0);
			ctl_s1.is_div    <= mode == MODE_DIV;
			ctl_s1.q_neg     <= a_in[WORD_BITS-1] ^ b_in[WORD_BITS-1];
		end
	end

	// Results of every mode other than divide.
	always_comb begin
		prod_sh = prod_s1 >>> FRAC_BITS;
		case (mode_s1)
			MODE_ADD:  res_c0 = a_s1 + b_s1;
			MODE_SUB:  res_c0 = a_s1 - b_s1;
			MODE_MUL:  res_c0 = prod_sh[WORD_BITS-1:0];
			MODE_MIN:  res_c0 = (a_s1 < b_s1) ? a_s1 : b_s1;
			MODE_MAX:  res_c0 = (a_s1 < b_s1) ? b_s1 : a_s1;
			MODE_INC:  res_c0 = a_s1 + WORD_BITS'(1);
			MODE_DEC:  res_c0 = a_s1 - WORD_BITS'(1);
			MODE_FINT: res_c0 = a_s1 <<< FRAC_BITS;
			MODE_TINT: res_c0 = a_s1 >>> FRAC_BITS;
			default:   res_c0 = '0;
		endcase
	end

	// Head of the chain.
	assign valid_c[0] = valid_s1;
	assign ctl_c[0]   = ctl_s1;
	assign res_c[0]   = res_c0;
	assign dvs_c[0]   = mag_b_s1;
	assign rem_c[0]   = '0;
	assign sh_c[0]    = QUOT_BITS'(mag_a_s1) << FRAC_BITS;

	// One division cell per quotient bit.
	for (genvar i = 0; i < QUOT_BITS; i++) begin : g_cell
		fpalu_cell #(
			.WORD_BITS(WORD_BITS),
			.QUOT_BITS(QUOT_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.prev_valid(valid_c[i]),
			.prev_ctl  (ctl_c[i]),
			.prev_res  (res_c[i]),
			.prev_dvs  (dvs_c[i]),
			.prev_rem  (rem_c[i]),
			.prev_sh   (sh_c[i]),
			.valid     (valid_c[i+1]),
			.ctl       (ctl_c[i+1]),
			.res       (res_c[i+1]),
			.dvs       (dvs_c[i+1]),
			.rem       (rem_c[i+1]),
			.sh        (sh_c[i+1])
		);
	end

	// Apply the quotient sign and pick the final result.
	always_comb begin
		quot_s = ctl_c[QUOT_BITS].q_neg ? QUOT_BITS'(-sh_c[QUOT_BITS]) : sh_c[QUOT_BITS];
		if (ctl_c[QUOT_BITS].div_zero) begin
			res_fin = '0;
		end else if (ctl_c[QUOT_BITS].is_div) begin
			res_fin = quot_s[WORD_BITS-1:0];
		end else begin
			res_fin = res_c[QUOT_BITS];
		end
	end

	// Output register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_c[QUOT_BITS];
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_fin;
			ctl_q <= ctl_c[QUOT_BITS];
		end
	end

	assign out_valid      = valid_q;
	assign result         = DATA_BITS'(res_q);
	assign a_greater      = ctl_q.a_greater;
	assign a_less         = ctl_q.a_less;
	assign a_equal        = ctl_q.a_equal;
	assign divide_by_zero = ctl_q.div_zero;

endmodule

// ===== hw/rtl/fpalu_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpalu_cell
// One restoring-division cell: settles one quotient bit and hands the word on.
// ----------------------------------------------------------------------------
module fpalu_cell #(
	parameter int WORD_BITS = fpalu_pkg::WORD_BITS_DEF,
	parameter int QUOT_BITS = fpalu_pkg::WORD_BITS_DEF + fpalu_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic                  prev_valid,
	input  fpalu_pkg::cell_ctl_t  prev_ctl,
	input  logic [WORD_BITS-1:0]  prev_res,
	input  logic [WORD_BITS-1:0]  prev_dvs,
	input  logic [WORD_BITS-1:0]  prev_rem,
	input  logic [QUOT_BITS-1:0]  prev_sh,
	output logic                  valid,
	output fpalu_pkg::cell_ctl_t  ctl,
	output logic [WORD_BITS-1:0]  res,
	output logic [WORD_BITS-1:0]  dvs,
	output logic [WORD_BITS-1:0]  rem,
	output logic [QUOT_BITS-1:0]  sh
);
	import fpalu_pkg::*;

	logic [WORD_BITS:0]   trial;
	logic [WORD_BITS:0]   diff;
	logic                 fits;
	logic [WORD_BITS-1:0] rem_next;
	logic [QUOT_BITS-1:0] sh_next;

	logic                 valid_q;
	cell_ctl_t            ctl_q;
	logic [WORD_BITS-1:0] res_q;
	logic [WORD_BITS-1:0] dvs_q;
	logic [WORD_BITS-1:0] rem_q;
	logic [QUOT_BITS-1:0] sh_q;

	// Bring down the next dividend bit and try to subtract the divisor.
	always_comb begin
		trial    = {prev_rem, prev_sh[QUOT_BITS-1]};
		diff     = trial - {1'b0, prev_dvs};
		fits     = ~diff[WORD_BITS];
		rem_next = fits ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
		sh_next  = {prev_sh[QUOT_BITS-2:0], fits};
	end

	// Valid bit of this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= prev_valid;
		end
	end

	// Word payload of this cell.
	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_q <= prev_ctl;
			res_q <= prev_res;
			dvs_q <= prev_dvs;
			rem_q <= rem_next;
			sh_q  <= sh_next;
		end
	end

	assign valid = valid_q;
	assign ctl   = ctl_q;
	assign res   = res_q;
	assign dvs   = dvs_q;
	assign rem   = rem_q;
	assign sh    = sh_q;

endmodule

// ===== verif/tb_fixed_point_alu_q24_8.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_alu_q24_8
// Self-checking bench for the Q24.8 fixed-point ALU. A directed table covers
// the operand extremes, every operation, zero divisors and unknown modes;
// random words follow. Each word out is compared with a local prediction,
// with random gaps on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu_q24_8;
	import fpalu_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int N_RANDOM = 1150;
	localparam int LATENCY = 42;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [MODE_BITS-1:0] mode;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} alu_word_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic gt;
		logic lt;
		logic eq;
		logic dz;
	} alu_res_t;

	typedef struct {
		alu_word_t w;
		bit fixed;
		alu_res_t r;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [MODE_BITS-1:0] mode = '0;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] result;
	logic a_greater, a_less, a_equal, divide_by_zero;

	alu_res_t expected_results[$];
	int errors = 0;
	int n_checked = 0;
	int cycles = 0;
	bit hold_active = 1'b0;
	int mode_seen[16];

	fixed_point_alu_q24_8 i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_stall(out_stall),
		.result(result), .a_greater(a_greater), .a_less(a_less),
		.a_equal(a_equal), .divide_by_zero(divide_by_zero)
	);

	// Clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Cycle counter with a hard limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Predicts the ALU word for one operation in 64-bit signed arithmetic.
	function automatic alu_res_t alu_predict(alu_word_t w);
		longint sa, sb, r;
		alu_res_t o;
		sa = longint'(w.a);
		sb = longint'(w.b);
		r = 0;
		o.dz = 1'b0;
		case (w.mode)
			MODE_ADD: r = sa + sb;
			MODE_SUB: r = sa - sb;
			MODE_MUL: r = (sa * sb) >>> FRAC;
			MODE_DIV: begin
				if (sb == 0) o.dz = 1'b1;
				else r = (sa <<< FRAC) / sb;
			end
			MODE_MIN: r = (sa < sb) ? sa : sb;
			MODE_MAX: r = (sa < sb) ? sb : sa;
			MODE_INC: r = sa + 1;
			MODE_DEC: r = sa - 1;
			MODE_FINT: r = sa <<< FRAC;
			MODE_TINT: r = sa >>> FRAC;
			default: r = 0;
		endcase
		o.value = r[31:0];
		o.gt = sa > sb;
		o.lt = sa < sb;
		o.eq = sa == sb;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch at word %0d: %s got %h expected %h", n_checked, what, got, want);
	endtask

	// Presents one word and waits for it to be taken.
	task automatic send_word(alu_word_t w, alu_res_t r);
		mode <= w.mode;
		operand_a <= w.a;
		operand_b <= w.b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(r);
		mode_seen[w.mode]++;
	endtask

	// Mostly no gap, sometimes a short one, rarely a long one.
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) < 6) ? 0 :
			($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] random_operand();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff - $urandom_range(0, 2);
			1: return 32'sh80000000 + $urandom_range(0, 2);
			2: return $signed($urandom_range(0, 2047)) - 1024;
			3: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			default: return $urandom();
		endcase
	endfunction

	// Output side: random stalls, one long hold-off while inputs keep coming.
	initial begin
		int n;
		@(posedge arst_n);
		repeat (200) @(posedge clk);
		hold_active <= 1'b1;
		out_stall <= 1'b1;
		repeat (150) @(posedge clk);
		out_stall <= 1'b0;
		hold_active <= 1'b0;
		forever begin
			n = ($urandom_range(0, 9) < 6) ? 0 :
				($urandom_range(0, 19) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Checks every accepted output word against the oldest prediction.
	always @(posedge clk) begin
		alu_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected word", result, 32'h0);
			end else begin
				e = expected_results.pop_front();
				if (result !== e.value) report_mismatch("result", result, e.value);
				if (a_greater !== e.gt) report_mismatch("a_greater", a_greater, e.gt);
				if (a_less !== e.lt) report_mismatch("a_less", a_less, e.lt);
				if (a_equal !== e.eq) report_mismatch("a_equal", a_equal, e.eq);
				if (divide_by_zero !== e.dz)
					report_mismatch("divide_by_zero", divide_by_zero, e.dz);
			end
			n_checked++;
		end
	end

	// Stimulus.
	initial begin
		table_row_t rows[$];
		alu_word_t w;
		alu_res_t r;
		int wait_cycles;

		// Directed rows; fixed expectations only where they are obvious.
		rows.push_back('{'{MODE_ADD, 32'sh7fffffff, 32'sh1}, 1, '{32'sh80000000, 1, 0, 0, 0}});
		rows.push_back('{'{MODE_SUB, 32'sh80000000, 32'sh1}, 1, '{32'sh7fffffff, 0, 1, 0, 0}});
		rows.push_back('{'{MODE_DIV, 32'sh12345, 32'sh0}, 1, '{32'sh0, 1, 0, 0, 1}});
		rows.push_back('{'{MODE_DIV, 32'sh80000000, 32'sh0}, 1, '{32'sh0, 0, 1, 0, 1}});
		rows.push_back('{'{4'd10, 32'sh5, 32'sh5}, 1, '{32'sh0, 0, 0, 1, 0}});
		rows.push_back('{'{4'd15, 32'shffffffff, 32'sh7fffffff}, 1, '{32'sh0, 0, 1, 0, 0}});
		rows.push_back('{'{MODE_INC, 32'sh7fffffff, 32'sh0}, 1, '{32'sh80000000, 1, 0, 0, 0}});
		rows.push_back('{'{MODE_DEC, 32'sh80000000, 32'sh0}, 1, '{32'sh7fffffff, 0, 1, 0, 0}});
		rows.push_back('{'{MODE_MUL, 32'sh80000000, 32'sh80000000}, 0, '0});
		rows.push_back('{'{MODE_MUL, 32'sh7fffffff, 32'sh80000000}, 0, '0});
		rows.push_back('{'{MODE_MUL, -32'sh180, 32'sh100}, 0, '0});
		rows.push_back('{'{MODE_DIV, 32'sh80000000, -32'sh1}, 0, '0});
		rows.push_back('{'{MODE_DIV, -32'sh300, 32'sh200}, 0, '0});
		rows.push_back('{'{MODE_DIV, 32'sh7fffffff, 32'sh1}, 0, '0});
		rows.push_back('{'{MODE_MIN, 32'sh80000000, 32'sh7fffffff}, 0, '0});
		rows.push_back('{'{MODE_MAX, 32'sh80000000, 32'sh7fffffff}, 0, '0});
		rows.push_back('{'{MODE_FINT, 32'sh7fffffff, 32'sh0}, 0, '0});
		rows.push_back('{'{MODE_FINT, -32'sh3, 32'sh0}, 0, '0});
		rows.push_back('{'{MODE_TINT, -32'sh1, 32'sh0}, 0, '0});
		rows.push_back('{'{MODE_TINT, 32'sh80000000, 32'sh0}, 0, '0});
		rows.push_back('{'{MODE_TINT, 32'sh7fffffff, 32'shffffffff}, 0, '0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			r = rows[i].fixed ? rows[i].r : alu_predict(rows[i].w);
			send_word(rows[i].w, r);
			idle_gap();
		end

		// Random words; a few unknown modes mixed in.
		for (int i = 0; i < N_RANDOM; i++) begin
			w.mode = ($urandom_range(0, 19) == 0) ? MODE_BITS'($urandom_range(10, 15)) :
				MODE_BITS'($urandom_range(0, 9));
			w.a = random_operand();
			case ($urandom_range(0, 9))
				0: w.b = 0;
				1: w.b = w.a;
				default: w.b = random_operand();
			endcase
			send_word(w, alu_predict(w));
			// Keep offering back to back while the output is held off.
			if (!hold_active) idle_gap();
		end
		in_valid <= 1'b0;

		// Drain, then let the pipeline run empty before the last check.
		wait_cycles = 0;
		while (expected_results.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 10) @(posedge clk);
		if (expected_results.size() != 0) begin
			errors++;
			$display("%0d expected words never arrived", expected_results.size());
		end

		$display("checked %0d words over %0d cycles; per-mode counts add %0d sub %0d mul %0d",
			n_checked, cycles, mode_seen[0], mode_seen[1], mode_seen[2]);
		$display("div %0d min %0d max %0d inc %0d dec %0d from_int %0d to_int %0d",
			mode_seen[3], mode_seen[4], mode_seen[5], mode_seen[6], mode_seen[7],
			mode_seen[8], mode_seen[9]);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
